### hdl/sdcm_pkg.sv
// Package: shared types, constants and exp table function for the confidence map core
package sdcm_pkg;

  localparam int unsigned DISP_W  = 16;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned CONF_W  = 16;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned COL_W   = 11;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned SPAN_W  = 24;
  localparam int unsigned FW_W    = 12;
  localparam int unsigned FH_W    = 13;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;

  localparam logic [63:0] EXP_RATIO_Q32 = 64'd4268207462;
  localparam logic [24:0] ONE_Q24       = 25'd16777216;
  localparam logic [24:0] FLOOR_Q24     = 25'd5033165;

  localparam logic [2:0] ADDR_MIN  = 3'd0;
  localparam logic [2:0] ADDR_MAX  = 3'd1;
  localparam logic [2:0] ADDR_SPAN = 3'd2;
  localparam logic [2:0] ADDR_FW   = 3'd3;
  localparam logic [2:0] ADDR_FH   = 3'd4;

  // classified window item handed from front to back
  typedef struct packed {
    logic                     valid_px;
    logic [SUM_W-1:0]         sum;
    logic [CNT_W-1:0]         n;
    logic [DEPTH_W-1:0]       depth_off;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         column;
    logic                     frame_last;
  } sdcm_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] min_depth;
    logic [DEPTH_W-1:0] max_depth;
    logic [SPAN_W-1:0]  inv_span;
    logic [FW_W-1:0]    frame_width;
    logic [FH_W-1:0]    frame_height;
  } sdcm_cfg_t;

  function automatic logic [15:0] exp_entry(input int unsigned k);
    logic [63:0] acc;
    logic [63:0] e;
    logic [127:0] p;
    acc = 64'd1 << 32;
    for (int unsigned i = 0; i < k; i++) begin
      p = acc * EXP_RATIO_Q32 + (128'd1 << 31);
      acc = p[95:32];
    end
    e = (acc + 64'd32768) >> 16;
    return (e > 64'd65535) ? 16'hFFFF : e[15:0];
  endfunction

endpackage

### hdl/stereo_depth_confidence_map_core.sv
// Top level: stream ports, APB register file, front/queue/back wiring
// Takes one pixel per clock in raster order while in_tready is high and returns one confidence
// item per interior pixel. The front side (line-store memories, one read and one write per
// pixel) sets the one-pixel-per-clock rate; the back side (pipelined divide by the neighbour
// count, exp table, depth weight multiply) freezes while out_tvalid is high and out_tready is
// low, and in_tready drops once the four-entry queue plus the two front stages would hold
// four items.
module stereo_depth_confidence_map_core
  import sdcm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH      = 2048,
  parameter int unsigned EXP_TABLE_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // disparity[15:0], depth_mm[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // confidence[15:0], row[27:16], column[38:28], 0
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  sdcm_cfg_t cfg_r;
  logic [2:0] ri;
  assign ri = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_depth    <= 16'd100;
      cfg_r.max_depth    <= 16'd800;
      cfg_r.inv_span     <= 24'd23967;
      cfg_r.frame_width  <= 12'd640;
      cfg_r.frame_height <= 13'd480;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      case (ri)
        ADDR_MIN:  cfg_r.min_depth    <= cfg_pwdata[15:0];
        ADDR_MAX:  cfg_r.max_depth    <= cfg_pwdata[15:0];
        ADDR_SPAN: cfg_r.inv_span     <= cfg_pwdata[23:0];
        ADDR_FW:   cfg_r.frame_width  <= cfg_pwdata[11:0];
        ADDR_FH:   cfg_r.frame_height <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ri)
      ADDR_MIN:  cfg_prdata = {16'd0, cfg_r.min_depth};
      ADDR_MAX:  cfg_prdata = {16'd0, cfg_r.max_depth};
      ADDR_SPAN: cfg_prdata = {8'd0, cfg_r.inv_span};
      ADDR_FW:   cfg_prdata = {20'd0, cfg_r.frame_width};
      ADDR_FH:   cfg_prdata = {19'd0, cfg_r.frame_height};
      default:   cfg_prdata = '0;
    endcase
  end

  logic in_fire;
  logic f_vld;
  sdcm_item_t f_item;
  logic q_vld, q_pop;
  sdcm_item_t q_item;
  logic [QPTR_W:0] q_cnt;
  logic [1:0] inflight_r;
  logic [QPTR_W+2:0] total;

  // front has two item stages in flight; keep room for them in the queue
  assign total = (QPTR_W+3)'(q_cnt) + (QPTR_W+3)'(inflight_r[0]) +
                 (QPTR_W+3)'(inflight_r[1]);
  assign in_tready = total < (QPTR_W+3)'(QDEPTH);
  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) inflight_r <= '0;
    else inflight_r <= {inflight_r[0], in_fire};
  end

  sdcm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst_n, .in_fire,
    .disparity(in_tdata[15:0]), .depth_mm(in_tdata[31:16]),
    .cfg(cfg_r), .item_vld(f_vld), .item(f_item)
  );

  sdcm_queue u_queue (
    .clk, .rst_n, .wr_en(f_vld), .wr_data(f_item),
    .rd_en(q_pop), .rd_vld(q_vld), .rd_data(q_item), .count(q_cnt)
  );

  logic [CONF_W-1:0] conf;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] column;

  sdcm_back #(.EXP_TABLE_SIZE(EXP_TABLE_SIZE)) u_back (
    .clk, .rst_n, .q_vld, .q_item, .q_pop, .inv_span(cfg_r.inv_span),
    .out_tvalid, .out_tready, .conf, .row, .column, .frame_last(out_tlast)
  );

  assign out_tdata = {1'b0, column, row, conf};
endmodule

### hdl/sdcm_front.sv
// Front: line stores, 3x3 window, position tracking and window classification
module sdcm_front
  import sdcm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [DISP_W-1:0]    disparity,
  input  logic [DEPTH_W-1:0]   depth_mm,
  input  sdcm_cfg_t            cfg,
  output logic                 item_vld,
  output sdcm_item_t           item
);
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1) > FW_W ? $clog2(MAX_WIDTH + 1) : FW_W;

  logic [DISP_W-1:0]  top_mem [MAX_WIDTH];
  logic [DISP_W-1:0]  mid_mem [MAX_WIDTH];
  logic [DEPTH_W-1:0] z_mem   [MAX_WIDTH];

  logic [CW-1:0]   col_r, col_nxt;
  logic [FH_W-1:0] row_r, row_nxt;
  logic [CW-1:0]   wd;
  logic [FH_W-1:0] ht;

  // stage 1 registers (line store reads)
  logic               s1_vld_r;
  logic [DISP_W-1:0]  s1_top_r, s1_mid_r, s1_in_r;
  logic [DEPTH_W-1:0] s1_z_r;
  logic               s1_emit_r, s1_last_r;
  logic [CW-1:0]      s1_col_r;
  logic [FH_W-1:0]    s1_row_r;
  logic               s1_inb_r;

  logic [DISP_W-1:0]  win_r [9];
  logic [DEPTH_W-1:0] zd_r [2];

  always_comb begin
    wd = (cfg.frame_width < FW_W'(3)) ? CW'(3) :
         ({{(CW-FW_W){1'b0}}, cfg.frame_width} > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) :
         CW'(cfg.frame_width);
    ht = (cfg.frame_height < FH_W'(3)) ? FH_W'(3) :
         (cfg.frame_height > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : cfg.frame_height;
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (col_nxt >= wd) begin
      col_nxt = '0;
      row_nxt = row_r + FH_W'(1);
      if (row_nxt >= ht) begin
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_inb_r  <= col_r < CW'(MAX_WIDTH);
      s1_in_r   <= disparity;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_emit_r <= (row_r >= FH_W'(2)) && (col_r >= CW'(2)) && (row_r < ht) && (col_r < wd);
      s1_last_r <= (row_r == ht - FH_W'(1)) && (col_r == wd - CW'(1));
      if (col_r < CW'(MAX_WIDTH)) begin
        top_mem[col_r[AW-1:0]] <= mid_mem[col_r[AW-1:0]];
        mid_mem[col_r[AW-1:0]] <= disparity;
        z_mem[col_r[AW-1:0]]   <= depth_mm;
        s1_top_r <= top_mem[col_r[AW-1:0]];
        s1_mid_r <= mid_mem[col_r[AW-1:0]];
        s1_z_r   <= z_mem[col_r[AW-1:0]];
      end
    end
  end

  logic [DISP_W-1:0]  nw [9];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nw[k*3]   = win_r[k*3+1];
      nw[k*3+1] = win_r[k*3+2];
    end
    nw[2] = s1_inb_r ? s1_top_r : '0;
    nw[5] = s1_inb_r ? s1_mid_r : '0;
    nw[8] = s1_in_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) win_r[k] <= '0;
      zd_r[0] <= '0;
      zd_r[1] <= '0;
    end else if (s1_vld_r) begin
      for (int k = 0; k < 9; k++) win_r[k] <= nw[k];
      zd_r[1] <= zd_r[0];
      zd_r[0] <= s1_inb_r ? s1_z_r : '0;
    end
  end

  // classification on the updated window, centre depth = old zd_r[0]
  logic signed [DISP_W:0] dc, dv, df;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] n;
  logic [DEPTH_W-1:0] z;
  logic valid_px;
  always_comb begin
    z   = zd_r[0];
    dc  = {nw[4][DISP_W-1], nw[4]};
    sum = '0;
    n   = '0;
    for (int k = 0; k < 9; k++) begin
      dv = {nw[k][DISP_W-1], nw[k]};
      df = (dv > dc) ? dv - dc : dc - dv;
      if (dv > 0) begin
        sum = sum + SUM_W'(df[DISP_W-1:0]);
        n   = n + CNT_W'(1);
      end
    end
    valid_px = (dc > 0) && (z > cfg.min_depth) && (z < cfg.max_depth);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld <= 1'b0;
    end else begin
      item_vld <= s1_vld_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      item.valid_px   <= valid_px;
      item.sum        <= sum;
      item.n          <= n;
      item.depth_off  <= z - cfg.min_depth;
      item.row        <= ROW_W'(s1_row_r - FH_W'(1));
      item.column     <= COL_W'(s1_col_r - CW'(1));
      item.frame_last <= s1_last_r;
    end
  end
endmodule

### hdl/sdcm_queue.sv
// Short FIFO between front and back
module sdcm_queue
  import sdcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  sdcm_item_t wr_data,
  input  logic       rd_en,
  output logic       rd_vld,
  output sdcm_item_t rd_data,
  output logic [QPTR_W:0] count
);
  sdcm_item_t mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + QPTR_W'(1);
      if (rd_en) rp_r <= rp_r + QPTR_W'(1);
      cnt_r <= cnt_r + (QPTR_W+1)'(wr_en) - (QPTR_W+1)'(rd_en);
    end
  end
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
  assign rd_vld  = cnt_r != '0;
  assign rd_data = mem_r[rp_r];
  assign count   = cnt_r;
endmodule

### hdl/sdcm_back.sv
// Back: pipelined mean divide, exp lookup, depth weighting and output register
module sdcm_back
  import sdcm_pkg::*;
#(
  parameter int unsigned EXP_TABLE_SIZE = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_vld,
  input  sdcm_item_t        q_item,
  output logic              q_pop,
  input  logic [SPAN_W-1:0] inv_span,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CONF_W-1:0] conf,
  output logic [ROW_W-1:0]  row,
  output logic [COL_W-1:0]  column,
  output logic              frame_last
);
  localparam int unsigned IW = $clog2(EXP_TABLE_SIZE);
  localparam int unsigned NS = 6;

  logic [15:0] exp_rom [EXP_TABLE_SIZE];

  initial begin
    for (int unsigned k = 0; k < EXP_TABLE_SIZE; k++) exp_rom[k] = exp_entry(k);
  end

  // divide by n (0..9, at least 1 for a valid pixel) via restoring division, pipelined: 4 quotient bits per stage
  logic               v_r   [NS+4];
  sdcm_item_t         it_r  [NS+4];
  logic [SUM_W-1:0]   rem_r [NS];
  logic [SUM_W-1:0]   quo_r [NS];
  logic               hold;

  assign hold = out_tvalid && !out_tready;

  // stage 0: dividend = sum + n/2
  assign q_pop = q_vld && !hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS + 4; s++) v_r[s] <= 1'b0;
    end else if (!hold) begin
      v_r[0] <= q_pop;
      for (int s = 1; s < NS + 4; s++) v_r[s] <= v_r[s-1];
    end
  end

  logic [SUM_W-1:0] r_w [NS];
  logic [SUM_W-1:0] q_w [NS];
  logic [SUM_W+CNT_W-1:0] t;
  always_comb begin
    for (int s = 1; s < NS; s++) begin
      r_w[s] = rem_r[s-1];
      q_w[s] = quo_r[s-1];
      for (int b = 0; b < 4; b++) begin
        t = {{CNT_W{1'b0}}, r_w[s]} -
            ({{SUM_W{1'b0}}, it_r[s-1].n} << (SUM_W - 1 - ((s-1)*4 + b)));
        if (((s-1)*4 + b) < SUM_W && !t[SUM_W+CNT_W-1]) begin
          r_w[s] = t[SUM_W-1:0];
          q_w[s][SUM_W-1-((s-1)*4+b)] = 1'b1;
        end
      end
    end
    r_w[0] = '0;
    q_w[0] = '0;
  end

  logic [IW-1:0]   idx;
  logic [15:0]     e_r;
  logic [47:0]     prod_r;
  logic [24:0]     w;
  logic [24:0]     w_r;
  logic [15:0]     e2_r;
  logic [41:0]     cp_r;
  logic [CONF_W-1:0] c_r;

  always_comb begin
    idx = (quo_r[NS-1] > SUM_W'(EXP_TABLE_SIZE - 1)) ? IW'(EXP_TABLE_SIZE - 1)
                                                     : quo_r[NS-1][IW-1:0];
    w = (prod_r < 48'(ONE_Q24)) ? ONE_Q24 - prod_r[24:0] : '0;
    if (w < FLOOR_Q24) w = FLOOR_Q24;
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      it_r[0]  <= q_item;
      rem_r[0] <= q_item.sum + SUM_W'(q_item.n >> 1);
      quo_r[0] <= '0;
      for (int s = 1; s < NS; s++) begin
        it_r[s]  <= it_r[s-1];
        rem_r[s] <= r_w[s];
        quo_r[s] <= q_w[s];
      end
      it_r[NS]   <= it_r[NS-1];
      e_r        <= exp_rom[idx];
      prod_r     <= it_r[NS-1].depth_off * inv_span;
      it_r[NS+1] <= it_r[NS];
      e2_r       <= e_r;
      w_r        <= w;
      it_r[NS+2] <= it_r[NS+1];
      cp_r       <= e2_r * w_r + 42'd8388608;
      it_r[NS+3] <= it_r[NS+2];
      c_r        <= it_r[NS+2].valid_px ? cp_r[39:24] : '0;
    end
  end

  assign out_tvalid = v_r[NS+3];
  assign conf       = c_r;
  assign row        = it_r[NS+3].row;
  assign column     = it_r[NS+3].column;
  assign frame_last = it_r[NS+3].frame_last;
endmodule

### hdl/sdcm_checker.sv
// Port-level checker for the confidence map core, bound to the top level
module sdcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled item changed");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39] == 1'b0)
    else $error("pad bit set");
  a_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[27:16] != 12'd0 && out_tdata[38:28] != 11'd0)
    else $error("border position emitted");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");
endmodule

bind stereo_depth_confidence_map_core sdcm_checker u_sdcm_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
  .out_tdata, .out_tlast, .cfg_pready
);

### tb/sdcm_checker.sv
// Checker: watches the pixel, result and register ports, predicts confidence items and compares
`timescale 1ns / 1ps
module sdcm_scoreboard
  import sdcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // disparity[15:0], depth_mm[31:16]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // confidence[15:0], row[27:16], column[38:28], 0
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          pending
);

  localparam int LINE_MAX = 2048;
  localparam int TBL_SIZE = 1024;

  typedef struct packed {
    logic [CONF_W-1:0] confidence;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic              frame_last;
  } conf_item_t;

  conf_item_t       conf_q[$];
  logic [15:0]      exp_tbl [TBL_SIZE];
  logic [15:0]      disp_line [2*LINE_MAX];
  logic [15:0]      depth_line [LINE_MAX];
  logic [15:0]      win [9];
  logic [15:0]      zdly [2];
  int unsigned      col_cnt, row_cnt;
  logic [15:0]      lo_mm, hi_mm;
  logic [23:0]      span;
  logic [11:0]      width_reg;
  logic [12:0]      height_reg;

  assign pending = conf_q.size();

  initial begin
    logic [63:0]  acc;
    logic [63:0]  e;
    logic [127:0] p;
    acc = 64'd1 << 32;
    for (int k = 0; k < TBL_SIZE; k++) begin
      e = (acc + 64'd32768) >> 16;
      exp_tbl[k] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
      p = acc * EXP_RATIO_Q32 + (128'd1 << 31);
      acc = p[95:32];
    end
    for (int k = 0; k < 2*LINE_MAX; k++) disp_line[k] = '0;
    for (int k = 0; k < LINE_MAX; k++) depth_line[k] = '0;
  end

  function automatic logic [15:0] pixel_confidence(input logic [15:0] depth);
    int          ctr, v;
    int unsigned sum, n, mean, idx;
    logic [63:0] prod, w, r;
    ctr = $signed(win[4]);
    if (ctr <= 0 || depth <= lo_mm || depth >= hi_mm) return 16'd0;
    sum = 0;
    n = 0;
    for (int k = 0; k < 9; k++) begin
      v = $signed(win[k]);
      if (v > 0) begin
        sum += (v > ctr) ? v - ctr : ctr - v;
        n++;
      end
    end
    mean = (sum + n / 2) / n;
    idx = (mean > TBL_SIZE - 1) ? TBL_SIZE - 1 : mean;
    prod = 64'(depth - lo_mm) * 64'(span);
    w = (prod < 64'(ONE_Q24)) ? 64'(ONE_Q24) - prod : 64'd0;
    if (w < 64'(FLOOR_Q24)) w = 64'(FLOOR_Q24);
    r = (64'(exp_tbl[idx]) * w + (64'd1 << 23)) >> 24;
    return r[15:0];
  endfunction

  task automatic advance_pixel(input logic [15:0] d_in, input logic [15:0] z_in);
    int unsigned wd, ht, c, r;
    logic [15:0] top, mid, zread;
    conf_item_t  it;
    wd = (width_reg < 3) ? 3 : (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
    ht = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    c = col_cnt;
    r = row_cnt;
    top = '0;
    mid = '0;
    zread = '0;
    if (c < LINE_MAX) begin
      top = disp_line[c + LINE_MAX];
      mid = disp_line[c];
      disp_line[c + LINE_MAX] = mid;
      disp_line[c] = d_in;
      zread = depth_line[c];
      depth_line[c] = z_in;
    end
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = d_in;
    zdly[1] = zdly[0];
    zdly[0] = zread;
    if (r >= 2 && c >= 2 && r < ht && c < wd) begin
      it.confidence = pixel_confidence(zdly[1]);
      it.row = ROW_W'(r - 1);
      it.column = COL_W'(c - 1);
      it.frame_last = (r == ht - 1 && c == wd - 1);
      conf_q = {conf_q, it};
    end
    c++;
    if (c >= wd) begin
      c = 0;
      r++;
      if (r >= ht) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  always @(posedge clk) begin
    conf_item_t exp_it, got;
    if (!rst_n) begin
      conf_q.delete();
      mismatches <= 0;
      for (int k = 0; k < 9; k++) win[k] = '0;
      zdly[0] = '0;
      zdly[1] = '0;
      col_cnt = 0;
      row_cnt = 0;
      lo_mm = 16'd100;
      hi_mm = 16'd800;
      span = 24'd23967;
      width_reg = 12'd640;
      height_reg = 13'd480;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          ADDR_MIN:  lo_mm = cfg_pwdata[15:0];
          ADDR_MAX:  hi_mm = cfg_pwdata[15:0];
          ADDR_SPAN: span = cfg_pwdata[23:0];
          ADDR_FW:   width_reg = cfg_pwdata[11:0];
          ADDR_FH:   height_reg = cfg_pwdata[12:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) advance_pixel(in_tdata[15:0], in_tdata[31:16]);
      if (out_tvalid && out_tready) begin
        got.confidence = out_tdata[15:0];
        got.row = out_tdata[27:16];
        got.column = out_tdata[38:28];
        got.frame_last = out_tlast;
        if (conf_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected item: conf=%0d row=%0d col=%0d last=%0b",
                                        got.confidence, got.row, got.column, got.frame_last);
          mismatches <= mismatches + 1;
        end else begin
          exp_it = conf_q.pop_front();
          if (got !== exp_it) begin
            if (mismatches < 10)
              $display({"mismatch: exp conf=%0d row=%0d col=%0d last=%0b, ",
                        "got conf=%0d row=%0d col=%0d last=%0b"},
                       exp_it.confidence, exp_it.row, exp_it.column, exp_it.frame_last,
                       got.confidence, got.row, got.column, got.frame_last);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

### tb/tb_stereo_depth_confidence_map_core.sv
// Testbench top: clock, reset, pixel and register stimulus, result back-pressure and verdict
`timescale 1ns / 1ps
module tb_stereo_depth_confidence_map_core
  import sdcm_pkg::*;
;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // disparity[15:0], depth_mm[31:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // confidence[15:0], row[27:16], column[38:28], 0
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          mismatches;
  int          pending;
  logic        hold_active;
  logic [15:0] lo_cur, hi_cur;
  int          rand_items;

  stereo_depth_confidence_map_core DUT (.*);

  sdcm_scoreboard u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[stereo_depth_confidence_map_core] ERROR");
    $finish;
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_geometry(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [23:0] sp, input logic [11:0] w,
                              input logic [12:0] h);
    reg_write(ADDR_MIN, {16'd0, lo});
    reg_write(ADDR_MAX, {16'd0, hi});
    reg_write(ADDR_SPAN, {8'd0, sp});
    reg_write(ADDR_FW, {20'd0, w});
    reg_write(ADDR_FH, {19'd0, h});
    lo_cur = lo;
    hi_cur = hi;
  endtask

  task automatic send_px(input logic [15:0] d, input logic [15:0] z);
    int gap;
    gap = hold_active ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {z, d};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_px();
    logic [15:0] d, z;
    int          sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      d = 16'($urandom_range(1, 600));
      z = (32'(lo_cur) + 1 < 32'(hi_cur)) ? 16'($urandom_range(lo_cur + 1, hi_cur - 1))
                                         : 16'($urandom);
    end else begin
      d = 16'($urandom);
      z = 16'($urandom);
    end
    send_px(d, z);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_frames(input int count);
    for (int k = 0; k < count; k++) send_random_px();
    drain();
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    int gap, got;
    out_tready = 1'b0;
    hold_active = 1'b0;
    got = 0;
    @(posedge rst_n);
    forever begin
      if (got == 300) begin
        hold_active <= 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_active <= 1'b0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      got++;
    end
  end

  initial begin
    logic [15:0] lo, hi;
    logic [23:0] sp;
    int          w, h, nf;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    lo_cur = 16'd100;
    hi_cur = 16'd800;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full depth range; directed frame of 5x4
    set_geometry(16'd0, 16'd65535, 24'd256, 12'd5, 13'd4);
    send_px(16'h0001, 16'd1000); send_px(16'h0001, 16'd1000); send_px(16'hFFFF, 16'd1000);
    send_px(16'h0001, 16'd1000); send_px(16'h0001, 16'd1000);
    send_px(16'h0001, 16'd1000); send_px(16'h7FFF, 16'd1);     send_px(16'h0001, 16'd65534);
    send_px(16'h0000, 16'd100);  send_px(16'h8000, 16'd7);
    send_px(16'h0001, 16'd1000); send_px(16'h8000, 16'd500);   send_px(16'h0010, 16'd0);
    send_px(16'h0010, 16'd65535); send_px(16'h7FFF, 16'd1000);
    send_px(16'h0001, 16'd1000); send_px(16'h7FFF, 16'd1000);  send_px(16'h0002, 16'd1000);
    send_px(16'h0003, 16'd1000); send_px(16'h0001, 16'd1000);
    drain();
    send_frames(3 * 20);

    // empty depth range, width and height below the minimum
    set_geometry(16'd65535, 16'd0, 24'hFFFFFF, 12'd0, 13'd0);
    send_frames(9 * 4);

    rand_items = 0;
    while (rand_items < 1700) begin
      lo = 16'($urandom_range(0, 2000));
      hi = ($urandom_range(0, 7) == 0) ? 16'($urandom) : lo + 16'($urandom_range(1, 3000));
      sp = (hi > lo && $urandom_range(0, 4) != 0) ? 24'((32'd1 << 24) / (hi - lo))
                                                   : 24'($urandom);
      w = $urandom_range(3, 24);
      h = $urandom_range(3, 12);
      nf = $urandom_range(1, 3);
      set_geometry(lo, hi, sp, 12'(w), 13'(h));
      send_frames(nf * w * h);
      rand_items += nf * w * h;
    end

    if (mismatches == 0 && pending == 0) begin
      $display("[stereo_depth_confidence_map_core] OK");
    end else begin
      $display("[stereo_depth_confidence_map_core] ERROR");
    end
    $finish;
  end

endmodule
